### rtl/core/mbps_pkg.sv
// Package: shared constants and types of the masked byte pattern search unit.
package mbps_pkg;

    localparam int MAX_PAT_LEN = 32;
    localparam int LEN_W       = 6;
    localparam int OFFSET_W    = 32;
    localparam int COUNT_W     = 16;
    localparam int DATA_W      = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 3;

    localparam logic [LEN_W-1:0]    SINCE_MAX = 6'd63;
    localparam logic [OFFSET_W-1:0] POS_MAX   = '1;
    localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;

    typedef logic [DATA_W-1:0]   byte_t;
    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [OFFSET_W-1:0] offset_t;
    typedef logic [COUNT_W-1:0]  count_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO     = 3'd0,
        CFG_PAT_MID_LO = 3'd1,
        CFG_PAT_MID_HI = 3'd2,
        CFG_PAT_HI     = 3'd3,
        CFG_CARE_MASK  = 3'd4,
        CFG_PAT_LEN    = 3'd5,
        CFG_TARGET     = 3'd6
    } cfg_index_t;

endpackage

### rtl/core/mbps_if.sv
// Interfaces: byte input channel and result output channel.
interface mbps_in_if;
    logic               valid;
    logic               ready;
    mbps_pkg::byte_t    data_byte;
    logic               last_in_region;

    modport source (output valid, output data_byte, output last_in_region, input ready);
    modport sink   (input valid, input data_byte, input last_in_region, output ready);
endinterface

interface mbps_out_if;
    logic               valid;
    logic               ready;
    logic               found;
    mbps_pkg::offset_t  match_offset;

    modport source (output valid, output found, output match_offset, input ready);
    modport sink   (input valid, input found, input match_offset, output ready);
endinterface

### rtl/core/masked_byte_pattern_search_unit.sv
// Top level: masked byte pattern search over a streamed region.
//
//   channel  | direction | payload                      | transaction
//   ---------+-----------+------------------------------+---------------------
//   data     | in        | data_byte, last_in_region    | valid & ready
//   result   | out       | found, match_offset          | valid & ready
//   cfg      | in        | cfg_index, cfg_wdata         | cfg_we
//
// One byte per cycle. The window compare, counters and offset logic sit
// between the scan state registers and the result register, so a result
// appears in the cycle after its byte is taken. data.ready is low only while a
// result is held and result.ready is low; the result register frees up in
// the same cycle it is taken. Reset clears the scan state and the result
// valid flag and sets the configuration to its defaults; no clearing pass.
module masked_byte_pattern_search_unit (
    input  logic                                     clk,
    input  logic                                     rst_n,
    mbps_in_if.sink                                  data,
    mbps_out_if.source                               result,
    input  logic                                     cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]          cfg_wdata
);

    // configuration
    logic [4*mbps_pkg::CFG_DATA_W-1:0]  pat_reg;
    logic [mbps_pkg::MAX_PAT_LEN-1:0]   care_mask_reg;
    mbps_pkg::len_t                     pat_len_reg;
    mbps_pkg::count_t                   target_reg;

    // scan state
    mbps_pkg::byte_t                    win_reg [mbps_pkg::MAX_PAT_LEN];
    mbps_pkg::byte_t                    win_next [mbps_pkg::MAX_PAT_LEN];
    mbps_pkg::offset_t                  pos_reg;
    mbps_pkg::count_t                   matches_reg;
    mbps_pkg::len_t                     since_reg;
    logic                               reported_reg;

    // result register
    logic                               out_valid_reg;
    logic                               out_found_reg;
    mbps_pkg::offset_t                  out_offset_reg;

    logic                               accept;
    mbps_pkg::len_t                     len_eff;
    logic                               hit;
    mbps_pkg::len_t                     since_inc;
    logic                               check;
    logic                               is_target;
    logic                               emit_found;
    logic                               count_match;
    logic                               reported_next;
    mbps_pkg::offset_t                  start_offset;
    mbps_pkg::offset_t                  pos_inc;

    assign data.ready          = !out_valid_reg || result.ready;
    assign accept              = data.valid && data.ready;
    assign result.valid        = out_valid_reg;
    assign result.found        = out_found_reg;
    assign result.match_offset = out_offset_reg;

    // ---------------------------------------------------------------------
    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg       <= '0;
            care_mask_reg <= '1;
            pat_len_reg   <= mbps_pkg::LEN_W'(1);
            target_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (mbps_pkg::cfg_index_t'(cfg_index))
                mbps_pkg::CFG_PAT_LO:
                    pat_reg[0*mbps_pkg::CFG_DATA_W +: mbps_pkg::CFG_DATA_W] <= cfg_wdata;
                mbps_pkg::CFG_PAT_MID_LO:
                    pat_reg[1*mbps_pkg::CFG_DATA_W +: mbps_pkg::CFG_DATA_W] <= cfg_wdata;
                mbps_pkg::CFG_PAT_MID_HI:
                    pat_reg[2*mbps_pkg::CFG_DATA_W +: mbps_pkg::CFG_DATA_W] <= cfg_wdata;
                mbps_pkg::CFG_PAT_HI:
                    pat_reg[3*mbps_pkg::CFG_DATA_W +: mbps_pkg::CFG_DATA_W] <= cfg_wdata;
                mbps_pkg::CFG_CARE_MASK:
                    care_mask_reg <= cfg_wdata[mbps_pkg::MAX_PAT_LEN-1:0];
                mbps_pkg::CFG_PAT_LEN:
                    pat_len_reg <= cfg_wdata[mbps_pkg::LEN_W-1:0];
                mbps_pkg::CFG_TARGET:
                    target_reg <= cfg_wdata[mbps_pkg::COUNT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // length clamp, window shift and masked compare
    always_comb
    begin
        if (pat_len_reg == '0)
            len_eff = mbps_pkg::LEN_W'(1);
        else if (pat_len_reg > mbps_pkg::LEN_W'(mbps_pkg::MAX_PAT_LEN))
            len_eff = mbps_pkg::LEN_W'(mbps_pkg::MAX_PAT_LEN);
        else
            len_eff = pat_len_reg;
    end

    always_comb
    begin
        win_next[0] = data.data_byte;
        for (int i = 1; i < mbps_pkg::MAX_PAT_LEN; i++)
            win_next[i] = win_reg[i-1];
    end

    // Window tap k holds pattern position len-1-k; the pattern side is muxed
    // so the taps stay at fixed places.
    always_comb
    begin
        mbps_pkg::len_t pidx;
        hit = 1'b1;
        for (int k = 0; k < mbps_pkg::MAX_PAT_LEN; k++)
        begin
            pidx = len_eff - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(k);
            if ((mbps_pkg::LEN_W'(k) < len_eff) && care_mask_reg[pidx[4:0]]
                && (win_next[k] != pat_reg[{pidx[4:0], 3'b000} +: mbps_pkg::DATA_W]))
                hit = 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // match bookkeeping
    always_comb
    begin
        since_inc     = (since_reg == mbps_pkg::SINCE_MAX) ? since_reg
                                                           : since_reg + mbps_pkg::LEN_W'(1);
        check         = !reported_reg && (since_inc >= len_eff);
        is_target     = (matches_reg == target_reg);
        emit_found    = check && hit && is_target;
        count_match   = check && hit && !is_target;
        reported_next = reported_reg || emit_found;
        start_offset  = (pos_reg == mbps_pkg::POS_MAX)
                      ? pos_reg
                      : pos_reg - mbps_pkg::OFFSET_W'(len_eff - mbps_pkg::LEN_W'(1));
        pos_inc       = (pos_reg == mbps_pkg::POS_MAX) ? pos_reg
                                                       : pos_reg + mbps_pkg::OFFSET_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mbps_pkg::MAX_PAT_LEN; i++)
                win_reg[i] <= '0;
            pos_reg      <= '0;
            matches_reg  <= '0;
            since_reg    <= '0;
            reported_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (data.last_in_region)
            begin
                for (int i = 0; i < mbps_pkg::MAX_PAT_LEN; i++)
                    win_reg[i] <= '0;
                pos_reg      <= '0;
                matches_reg  <= '0;
                since_reg    <= '0;
                reported_reg <= 1'b0;
            end
            else
            begin
                for (int i = 0; i < mbps_pkg::MAX_PAT_LEN; i++)
                    win_reg[i] <= win_next[i];
                pos_reg      <= pos_inc;
                since_reg    <= count_match ? '0 : since_inc;
                if (count_match && (matches_reg != mbps_pkg::COUNT_MAX))
                    matches_reg <= matches_reg + mbps_pkg::COUNT_W'(1);
                reported_reg <= reported_next;
            end
        end
    end

    // ---------------------------------------------------------------------
    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= emit_found || (data.last_in_region && !reported_next);
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_found_reg  <= emit_found;
            out_offset_reg <= emit_found ? start_offset : '0;
        end
    end

    // ---------------------------------------------------------------------
    // checks
    a_region_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && data.last_in_region
        |=> (pos_reg == '0) && (matches_reg == '0) && !reported_reg && (since_reg == '0))
        else $error("scan state not cleared at region end");

    a_quiet_after_target: assert property (@(posedge clk) disable iff (!rst_n)
        accept && reported_reg && !data.last_in_region |=> !result.valid)
        else $error("result given after target already reported");

    a_stall_only_on_held: assert property (@(posedge clk) disable iff (!rst_n)
        !data.ready |-> result.valid && !result.ready)
        else $error("input stalled without a held result");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.found |-> result.match_offset == '0)
        else $error("not-found result with nonzero offset");

endmodule
